### sv/wpbf_pkg.sv
package wpbf_pkg;

  localparam int unsigned DefWindowDepth = 256;

  localparam int unsigned PosW    = 32;
  localparam int unsigned PenW    = 32;
  localparam int unsigned BudgetW = 32;
  localparam int unsigned PrefW   = 48;
  localparam int unsigned EntryW  = PosW + PrefW;

  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE
  } state_e;

endpackage

### sv/wpbf_ram.sv
module wpbf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/windowed_penalty_budget_filter_unit.sv
// channel   | direction | tdata (low bit up)                     | tuser
// s_axis    | in        | position, reach, drop_penalty (96 bit) | start_req
// m_axis    | out       | retain, zero fill to 8 bit             | window_overflow
// cfg       | in        | cfg_wdata_i = delta_budget, on cfg_we_i | -
//
// an item is accepted in the idle state, then a binary search runs over the
// filled entries (single read port of the ring memory, compare and next
// address in the same cycle); the last search cycle issues the prefix read,
// and the decide state decides and writes back; the ring holds 256 by default.
// reset clears the running total, head and fill count; ring contents are not
// cleared, only entries below the fill count are ever read.
// a result waits in the output register; the next item is taken meanwhile and
// stalls in its decide cycle until that result has been taken.
module windowed_penalty_budget_filter_unit #(
  parameter int unsigned WINDOW_DEPTH = wpbf_pkg::DefWindowDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         cfg_we_i,
  input  logic [wpbf_pkg::BudgetW-1:0] cfg_wdata_i,   // delta_budget

  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [wpbf_pkg::InDataW-1:0] s_axis_tdata,  // position, reach, drop_penalty
  input  logic                         s_axis_tuser,  // start_req

  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [wpbf_pkg::OutDataW-1:0] m_axis_tdata, // retain, zero fill
  output logic                          m_axis_tuser  // window_overflow
);

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned PosW  = wpbf_pkg::PosW;
  localparam int unsigned PenW  = wpbf_pkg::PenW;
  localparam int unsigned PrefW = wpbf_pkg::PrefW;
  localparam int unsigned EntryW = wpbf_pkg::EntryW;

  wpbf_pkg::state_e state_q, state_d;

  logic [wpbf_pkg::BudgetW-1:0] budget_q;
  logic [PrefW-1:0] total_q, total_d;
  logic [AW-1:0]    head_q, head_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic [CW-1:0]    first_q, first_d;
  logic [CW-1:0]    count_q, count_d;
  logic             pending_q, pending_d;
  logic [PosW-1:0]  pos_q;
  logic [PosW-1:0]  reach_q;
  logic [PenW-1:0]  pen_q;
  logic             out_valid_q, out_valid_d;
  logic             out_retain_q;
  logic             out_ovf_q;

  logic             in_fire;
  logic             out_free;
  logic             decide_fire;

  logic             ram_we;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [EntryW-1:0] ram_wdata;
  logic [EntryW-1:0] ram_rdata;

  logic [SW-1:0]    oldest_sum;
  logic [AW-1:0]    oldest;
  logic [CW-1:0]    step_cur;
  logic             probe_le;
  logic [CW-1:0]    first_nx;
  logic [CW-1:0]    count_nx;
  logic [CW-1:0]    age_sel;
  logic [SW-1:0]    slot_sum;
  logic [AW-1:0]    slot_sel;

  logic             hit;
  logic [PrefW-1:0] window_sum;
  logic [PrefW:0]   need;
  logic             keep;
  logic             overflow;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // oldest slot = head - fill, modulo the ring depth
  assign oldest_sum = SW'(head_q) + SW'(WINDOW_DEPTH) - SW'(fill_q);
  assign oldest = (oldest_sum >= SW'(WINDOW_DEPTH)) ?
                  AW'(oldest_sum - SW'(WINDOW_DEPTH)) : AW'(oldest_sum);

  // fold in the probe that just came back, then pick the next probe
  assign step_cur = count_q >> 1;
  assign probe_le = ram_rdata[PosW-1:0] <= reach_q;

  always_comb begin
    first_nx = first_q;
    count_nx = count_q;
    if (pending_q) begin
      if (probe_le) begin
        first_nx = first_q + step_cur + CW'(1);
        count_nx = count_q - step_cur - CW'(1);
      end else begin
        count_nx = step_cur;
      end
    end
  end

  assign age_sel  = (count_nx != '0) ? first_nx + (count_nx >> 1) : first_nx;
  assign slot_sum = SW'(oldest) + SW'(age_sel);
  assign slot_sel = (slot_sum >= SW'(WINDOW_DEPTH)) ?
                    AW'(slot_sum - SW'(WINDOW_DEPTH)) : AW'(slot_sum);

  // decision on the prefix read of the first entry above reach
  assign hit        = first_q < fill_q;
  assign window_sum = hit ? total_q - ram_rdata[EntryW-1:PosW] : '0;
  assign need       = {1'b0, window_sum} + (PrefW+1)'(pen_q);
  assign keep       = need > (PrefW+1)'(budget_q);
  assign overflow   = hit && (first_q == '0) && (fill_q == CW'(WINDOW_DEPTH));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      wpbf_pkg::S_IDLE: begin
        if (s_axis_tvalid) state_d = wpbf_pkg::S_SEARCH;
      end
      wpbf_pkg::S_SEARCH: begin
        if (count_nx == '0) state_d = wpbf_pkg::S_DECIDE;
      end
      wpbf_pkg::S_DECIDE: begin
        if (out_free) state_d = wpbf_pkg::S_IDLE;
      end
      default: state_d = wpbf_pkg::S_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    s_axis_tready = 1'b0;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    decide_fire   = 1'b0;
    pending_d     = 1'b0;
    case (state_q)
      wpbf_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
      end
      wpbf_pkg::S_SEARCH: begin
        pending_d = count_nx != '0;
        ram_re    = (count_nx != '0) || (first_nx < fill_q);
      end
      wpbf_pkg::S_DECIDE: begin
        decide_fire = out_free;
        ram_we      = out_free;
        pending_d   = 1'b0;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  assign ram_raddr = slot_sel;
  assign ram_wdata = {total_q, pos_q};

  always_comb begin
    total_d     = total_q;
    head_d      = head_q;
    fill_d      = fill_q;
    first_d     = first_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    if (in_fire) begin
      first_d = '0;
      if (s_axis_tuser) begin
        total_d = '0;
        head_d  = '0;
        fill_d  = '0;
        count_d = '0;
      end else begin
        count_d = fill_q;
      end
    end
    if (state_q == wpbf_pkg::S_SEARCH) begin
      first_d = first_nx;
      count_d = count_nx;
    end
    if (decide_fire) begin
      out_valid_d = 1'b1;
      head_d = (head_q == AW'(WINDOW_DEPTH - 1)) ? '0 : head_q + AW'(1);
      if (fill_q != CW'(WINDOW_DEPTH)) fill_d = fill_q + CW'(1);
      if (!keep) total_d = total_q + PrefW'(pen_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wpbf_pkg::S_IDLE;
      budget_q    <= '0;
      total_q     <= '0;
      head_q      <= '0;
      fill_q      <= '0;
      first_q     <= '0;
      count_q     <= '0;
      pending_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      first_q     <= first_d;
      count_q     <= count_d;
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) budget_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pos_q   <= s_axis_tdata[PosW-1:0];
      reach_q <= s_axis_tdata[2*PosW-1:PosW];
      pen_q   <= s_axis_tdata[2*PosW+PenW-1:2*PosW];
    end
    if (decide_fire) begin
      out_retain_q <= keep;
      out_ovf_q    <= overflow;
    end
  end

  // position in the low bits, prefix total in front of it above
  wpbf_ram #(
    .Width(EntryW),
    .Depth(WINDOW_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(head_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(wpbf_pkg::OutDataW-1){1'b0}}, out_retain_q};
  assign m_axis_tuser  = out_ovf_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(WINDOW_DEPTH))
    else $error("fill count beyond ring depth");

  a_search_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wpbf_pkg::S_SEARCH) |-> (SW'(first_q) + SW'(count_q) <= SW'(fill_q)))
    else $error("search range leaves the filled part of the ring");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("ring read and write in the same cycle");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == wpbf_pkg::S_SEARCH) && (first_q == '0))
    else $error("accepted item did not start a search");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    decide_fire |=> out_valid_q && (state_q == wpbf_pkg::S_IDLE))
    else $error("decision did not load the output register");

endmodule
